/* src/fhpc_pkg.sv */
// Shared constants and table builders for the fuzzy heater power controller.
`default_nettype none

package fhpc_pkg;

  // Field widths
  localparam int TEMP_W  = 12;
  localparam int HUM_W   = 10;
  localparam int POWER_W = 10;

  // Default membership fraction bits
  localparam int MEMBERSHIP_BITS_DEF = 8;

  // Temperature breakpoints, tenths of a degree
  localparam int T_LOW_A  = 150;
  localparam int T_LOW_B  = 200;
  localparam int T_NORM_A = 150;
  localparam int T_NORM_B = 170;
  localparam int T_NORM_C = 230;
  localparam int T_NORM_D = 250;
  localparam int T_HIGH_A = 200;
  localparam int T_HIGH_B = 250;

  // Humidity breakpoints, tenths of a percent
  localparam int H_LOW_A  = 300;
  localparam int H_LOW_B  = 400;
  localparam int H_NORM_A = 300;
  localparam int H_NORM_B = 400;
  localparam int H_NORM_C = 500;
  localparam int H_NORM_D = 600;
  localparam int H_HIGH_A = 500;
  localparam int H_HIGH_B = 600;

  // Output centers, tenths of a percent
  localparam int CTR_LOW  = 200;
  localparam int CTR_NORM = 500;
  localparam int CTR_HIGH = 800;

  // Slope lengths (lookup table depths)
  localparam int SPAN_20  = 20;
  localparam int SPAN_50  = 50;
  localparam int SPAN_100 = 100;

  // Slope values: (d * 2^mb) / span, truncated; evaluated at elaboration only
  function automatic int ramp20(input int d, input int mb);
    return (d << mb) / 20;
  endfunction

  function automatic int ramp50(input int d, input int mb);
    return (d << mb) / 50;
  endfunction

  function automatic int ramp100(input int d, input int mb);
    return (d << mb) / 100;
  endfunction

endpackage

`default_nettype wire

/* src/fhpc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with flow control.
`default_nettype none

module fhpc_div
  import fhpc_pkg::*;
#(
  parameter int MEMBERSHIP_BITS = MEMBERSHIP_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [MEMBERSHIP_BITS+10:0]  in_num,
  input  wire logic [MEMBERSHIP_BITS+1:0]   in_den,
  input  wire logic                         in_nf,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [POWER_W-1:0]                out_q,
  output logic                              out_nf
);

  localparam int QB = POWER_W;
  localparam int NW = MEMBERSHIP_BITS + 11;
  localparam int DW = MEMBERSHIP_BITS + 2;

  logic [QB-1:0] v_r;
  logic [NW-1:0] rem_r [QB];
  logic [QB-1:0] q_r   [QB];
  logic [DW-1:0] den_r [QB];
  logic [QB-1:0] nf_r;
  logic [QB:0]   rdy;

  // Backpressure: a stage takes data when empty or when it moves on
  assign rdy[QB] = !out_stall;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [NW-1:0] rem_in;
    logic [NW-1:0] trial;
    logic [NW-1:0] rem_nxt;
    logic [QB-1:0] q_in;
    logic [QB-1:0] q_nxt;
    logic [DW-1:0] den_in;
    logic          nf_in;
    logic          v_in;

    assign rdy[k] = !v_r[k] || rdy[k+1];

    if (k == 0) begin : g_first
      assign rem_in = in_num;
      assign q_in   = '0;
      assign den_in = in_den;
      assign nf_in  = in_nf;
      assign v_in   = in_valid;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
      assign den_in = den_r[k-1];
      assign nf_in  = nf_r[k-1];
      assign v_in   = v_r[k-1];
    end

    // One trial subtract of the shifted divisor
    assign trial = NW'(den_in) << (QB - 1 - k);

    always_comb begin
      rem_nxt = rem_in;
      q_nxt   = q_in;
      if (rem_in >= trial) begin
        rem_nxt             = rem_in - trial;
        q_nxt[QB - 1 - k]   = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        rem_r[k] <= rem_nxt;
        q_r[k]   <= q_nxt;
        den_r[k] <= den_in;
        nf_r[k]  <= nf_in;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[QB-1];
  assign out_q     = q_r[QB-1];
  assign out_nf    = nf_r[QB-1];

endmodule

`default_nettype wire

/* src/fuzzy_heater_power_controller.sv */
// Fuzzy heater power controller: top level with fuzzify, rule and divide stages.
//
// Usage:
//   Input channel carries one temperature/humidity sample per transaction
//   (in_valid / in_stall). Result channel carries one heater power and a
//   no-rule flag per transaction (out_valid / out_stall).
//   Stages from input transaction to out_valid:
//   one stage grades the memberships, one forms rule strengths and the
//   weighted sum, and ten stages run the restoring divider, one quotient
//   bit per stage. The last divider stage is the output register.
//   Throughput: one transaction per cycle while out_stall is low, set by the
//   one-bit-per-stage divider pipeline.
//   Reset (rst_n low, synchronous) empties every stage; results in flight
//   are dropped. Payload registers are not cleared.
//   When the receiver stalls, stages fill up from the output backward; the
//   input keeps accepting until the first stage has no free slot, and
//   in_stall rises only while a result waits at the output.
`default_nettype none

module fuzzy_heater_power_controller
  import fhpc_pkg::*;
#(
  parameter int MEMBERSHIP_BITS = MEMBERSHIP_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [TEMP_W-1:0]  in_temperature,
  input  wire logic [HUM_W-1:0]          in_humidity,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [POWER_W-1:0]             out_heater_power,
  output logic                           out_no_rule_fired
);

  localparam int MW   = MEMBERSHIP_BITS + 1;
  localparam int DW   = MEMBERSHIP_BITS + 2;
  localparam int NW   = MEMBERSHIP_BITS + 11;
  localparam int TXW  = TEMP_W + 1;
  localparam int I20  = $clog2(SPAN_20);
  localparam int I50  = $clog2(SPAN_50);
  localparam int I100 = $clog2(SPAN_100);
  localparam logic [MW-1:0] ONE_M = {1'b1, {MEMBERSHIP_BITS{1'b0}}};

  typedef logic [MW-1:0] tab20_t  [SPAN_20];
  typedef logic [MW-1:0] tab50_t  [SPAN_50];
  typedef logic [MW-1:0] tab100_t [SPAN_100];

  function automatic tab20_t build20();
    tab20_t tb;
    for (int d = 0; d < SPAN_20; d++) tb[d] = MW'(ramp20(d, MEMBERSHIP_BITS));
    return tb;
  endfunction

  function automatic tab50_t build50();
    tab50_t tb;
    for (int d = 0; d < SPAN_50; d++) tb[d] = MW'(ramp50(d, MEMBERSHIP_BITS));
    return tb;
  endfunction

  function automatic tab100_t build100();
    tab100_t tb;
    for (int d = 0; d < SPAN_100; d++) tb[d] = MW'(ramp100(d, MEMBERSHIP_BITS));
    return tb;
  endfunction

  localparam tab20_t  TAB20  = build20();
  localparam tab50_t  TAB50  = build50();
  localparam tab100_t TAB100 = build100();

  // Flow control signals
  logic rdy_a;
  logic rdy_b;
  logic div_rdy;

  // Stage A registers: six memberships
  logic          va_r;
  logic [MW-1:0] tl_r, tn_r, th_r, hl_r, hn_r, hh_r;
  logic [MW-1:0] tl_nxt, tn_nxt, th_nxt, hl_nxt, hn_nxt, hh_nxt;

  // Stage B registers: weighted sum and total strength
  logic          vb_r;
  logic [NW-1:0] num_r, num_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic          nf_r, nf_nxt;
  logic [MW-1:0] r1, r2, r3;

  // Divider outputs
  logic               div_nf;
  logic [POWER_W-1:0] div_q;

  // Distances into the slopes
  logic signed [TXW-1:0] t_ext;
  logic [TXW-1:0]        d_tl, d_tnr, d_tnf, d_th;
  logic [HUM_W-1:0]      d_hl, d_hnr, d_hnf, d_hh;

  assign t_ext = TXW'(in_temperature);
  assign d_tl  = TXW'(T_LOW_B) - t_ext;
  assign d_tnr = t_ext - TXW'(T_NORM_A);
  assign d_tnf = TXW'(T_NORM_D) - t_ext;
  assign d_th  = t_ext - TXW'(T_HIGH_A);
  assign d_hl  = HUM_W'(H_LOW_B) - in_humidity;
  assign d_hnr = in_humidity - HUM_W'(H_NORM_A);
  assign d_hnf = HUM_W'(H_NORM_D) - in_humidity;
  assign d_hh  = in_humidity - HUM_W'(H_HIGH_A);

  // Temperature memberships; flat values at the breakpoints
  always_comb begin
    if (t_ext <= TXW'(T_LOW_A))       tl_nxt = ONE_M;
    else if (t_ext >= TXW'(T_LOW_B))  tl_nxt = '0;
    else                              tl_nxt = TAB50[d_tl[I50-1:0]];

    if (t_ext <= TXW'(T_NORM_A) || t_ext >= TXW'(T_NORM_D)) begin
      tn_nxt = '0;
    end else if (t_ext >= TXW'(T_NORM_B) && t_ext <= TXW'(T_NORM_C)) begin
      tn_nxt = ONE_M;
    end else if (t_ext < TXW'(T_NORM_B)) begin
      tn_nxt = TAB20[d_tnr[I20-1:0]];
    end else begin
      tn_nxt = TAB20[d_tnf[I20-1:0]];
    end

    if (t_ext <= TXW'(T_HIGH_A))      th_nxt = '0;
    else if (t_ext >= TXW'(T_HIGH_B)) th_nxt = ONE_M;
    else                              th_nxt = TAB50[d_th[I50-1:0]];
  end

  // Humidity memberships
  always_comb begin
    if (in_humidity <= HUM_W'(H_LOW_A))      hl_nxt = ONE_M;
    else if (in_humidity >= HUM_W'(H_LOW_B)) hl_nxt = '0;
    else                                     hl_nxt = TAB100[d_hl[I100-1:0]];

    if (in_humidity <= HUM_W'(H_NORM_A) || in_humidity >= HUM_W'(H_NORM_D)) begin
      hn_nxt = '0;
    end else if (in_humidity >= HUM_W'(H_NORM_B) && in_humidity <= HUM_W'(H_NORM_C)) begin
      hn_nxt = ONE_M;
    end else if (in_humidity < HUM_W'(H_NORM_B)) begin
      hn_nxt = TAB100[d_hnr[I100-1:0]];
    end else begin
      hn_nxt = TAB100[d_hnf[I100-1:0]];
    end

    if (in_humidity <= HUM_W'(H_HIGH_A))      hh_nxt = '0;
    else if (in_humidity >= HUM_W'(H_HIGH_B)) hh_nxt = ONE_M;
    else                                      hh_nxt = TAB100[d_hh[I100-1:0]];
  end

  // Stage A
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (rdy_a) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      tl_r <= tl_nxt;
      tn_r <= tn_nxt;
      th_r <= th_nxt;
      hl_r <= hl_nxt;
      hn_r <= hn_nxt;
      hh_r <= hh_nxt;
    end
  end

  // Rule strengths and weighted sum
  assign r1 = (tl_r < hl_r) ? tl_r : hl_r;
  assign r2 = (tn_r < hn_r) ? tn_r : hn_r;
  assign r3 = (th_r > hh_r) ? th_r : hh_r;

  assign num_nxt = NW'(r1) * NW'(CTR_LOW) + NW'(r2) * NW'(CTR_NORM)
                 + NW'(r3) * NW'(CTR_HIGH);
  assign den_nxt = DW'(r1) + DW'(r2) + DW'(r3);
  assign nf_nxt  = (den_nxt == '0);

  // Stage B
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (rdy_b) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
      nf_r  <= nf_nxt;
    end
  end

  // Ready chain toward the input
  assign rdy_b    = !vb_r || div_rdy;
  assign rdy_a    = !va_r || rdy_b;
  assign in_stall = !rdy_a;

  fhpc_div #(
    .MEMBERSHIP_BITS (MEMBERSHIP_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vb_r),
    .in_ready  (div_rdy),
    .in_num    (num_r),
    .in_den    (den_r),
    .in_nf     (nf_r),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_q     (div_q),
    .out_nf    (div_nf)
  );

  // No rule fired: zero power
  assign out_heater_power  = div_nf ? '0 : div_q;
  assign out_no_rule_fired = div_nf;

endmodule

`default_nettype wire

/* src/fhpc_checker.sv */
// Port-level assertions for the fuzzy heater power controller, bound to the top.
`default_nettype none

module fhpc_checker
  import fhpc_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire logic signed [TEMP_W-1:0]  in_temperature,
  input wire logic [HUM_W-1:0]          in_humidity,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [POWER_W-1:0]        out_heater_power,
  input wire logic                      out_no_rule_fired
);

  // Input backs up only while a result waits at the output
  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output stage");

  // No fired rule gives zero power
  a_nofire_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_rule_fired) |-> (out_heater_power == '0))
    else $error("power nonzero with no rule fired");

  // Weighted average stays between the outer centers
  a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_no_rule_fired) |->
      (out_heater_power >= POWER_W'(CTR_LOW) && out_heater_power <= POWER_W'(CTR_HIGH)))
    else $error("power outside center range");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_heater_power) && $stable(out_no_rule_fired)))
    else $error("stalled result changed");

endmodule

bind fuzzy_heater_power_controller fhpc_checker u_fhpc_checker (.*);

`default_nettype wire

/* bench/fhpc_power_checker.sv */
// Checker for the fuzzy heater power controller: predicts every heater power and compares it.
module fhpc_power_checker
  import fhpc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic signed [TEMP_W-1:0] in_temperature,
  input  logic [HUM_W-1:0]         in_humidity,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [POWER_W-1:0]       out_heater_power,
  input  logic                     out_no_rule_fired,
  output int                       fail_count,
  output int                       awaiting,
  output int                       compared,
  output int                       idle_rules
);

  // Membership scale: full membership is 2^FRAC_BITS
  localparam int              FRAC_BITS = MEMBERSHIP_BITS_DEF;
  localparam longint unsigned FULL      = 64'd1 << FRAC_BITS;

  // Temperature curves, tenths of a degree
  localparam int TEMP_COOL_0 = 150;
  localparam int TEMP_COOL_1 = 200;
  localparam int TEMP_MID_0  = 150;
  localparam int TEMP_MID_1  = 170;
  localparam int TEMP_MID_2  = 230;
  localparam int TEMP_MID_3  = 250;
  localparam int TEMP_HOT_0  = 200;
  localparam int TEMP_HOT_1  = 250;

  // Humidity curves, tenths of a percent
  localparam int HUM_DRY_0 = 300;
  localparam int HUM_DRY_1 = 400;
  localparam int HUM_MID_0 = 300;
  localparam int HUM_MID_1 = 400;
  localparam int HUM_MID_2 = 500;
  localparam int HUM_MID_3 = 600;
  localparam int HUM_WET_0 = 500;
  localparam int HUM_WET_1 = 600;

  // Power centers, tenths of a percent
  localparam longint unsigned POWER_LOW  = 200;
  localparam longint unsigned POWER_MID  = 500;
  localparam longint unsigned POWER_HIGH = 800;

  typedef struct packed {
    logic [POWER_W-1:0] power;
    logic               no_rule;
  } heater_result_t;

  heater_result_t expected_power_q[$];

  // Falling slope: full at or below a, zero at or above b, truncated between
  function automatic longint unsigned falling(input int v, input int a, input int b);
    if (v <= a) return FULL;
    if (v >= b) return 0;
    return (longint'(b - v) * FULL) / longint'(b - a);
  endfunction

  // Rising slope: zero at or below a, full at or above b, truncated between
  function automatic longint unsigned rising(input int v, input int a, input int b);
    if (v <= a) return 0;
    if (v >= b) return FULL;
    return (longint'(v - a) * FULL) / longint'(b - a);
  endfunction

  // Trapezoid a/b/c/d, zero at or outside the feet
  function automatic longint unsigned plateau(input int v, input int a, input int b,
                                              input int c, input int d);
    if (v <= a || v >= d) return 0;
    if (v >= b && v <= c) return FULL;
    if (v < b) return rising(v, a, b);
    return falling(v, c, d);
  endfunction

  // Rule strengths and weighted-average defuzzification
  function automatic heater_result_t predict_heater_power(
      input logic signed [TEMP_W-1:0] temp, input logic [HUM_W-1:0] hum);
    int              tv;
    int              hv;
    longint unsigned t_part;
    longint unsigned h_part;
    longint unsigned cold_rule;
    longint unsigned fair_rule;
    longint unsigned hot_rule;
    longint unsigned num;
    longint unsigned den;
    heater_result_t  res;
    tv = temp;
    hv = hum;
    t_part    = falling(tv, TEMP_COOL_0, TEMP_COOL_1);
    h_part    = falling(hv, HUM_DRY_0, HUM_DRY_1);
    cold_rule = (t_part < h_part) ? t_part : h_part;
    t_part    = plateau(tv, TEMP_MID_0, TEMP_MID_1, TEMP_MID_2, TEMP_MID_3);
    h_part    = plateau(hv, HUM_MID_0, HUM_MID_1, HUM_MID_2, HUM_MID_3);
    fair_rule = (t_part < h_part) ? t_part : h_part;
    t_part    = rising(tv, TEMP_HOT_0, TEMP_HOT_1);
    h_part    = rising(hv, HUM_WET_0, HUM_WET_1);
    hot_rule  = (t_part > h_part) ? t_part : h_part;
    num = cold_rule * POWER_LOW + fair_rule * POWER_MID + hot_rule * POWER_HIGH;
    den = cold_rule + fair_rule + hot_rule;
    if (den == 0) begin
      res.power   = '0;
      res.no_rule = 1'b1;
    end else begin
      res.power   = POWER_W'(num / den);
      res.no_rule = 1'b0;
    end
    return res;
  endfunction

  initial begin
    fail_count = 0;
    awaiting   = 0;
    compared   = 0;
    idle_rules = 0;
  end

  // Watch both channels; retire results first, then queue the new prediction
  always @(posedge clk) begin
    heater_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_power_q.size() == 0) begin
          fail_count++;
          $display("%0t: result transaction with nothing expected: power=%0d flag=%0b",
                   $time, out_heater_power, out_no_rule_fired);
        end else begin
          want = expected_power_q.pop_front();
          compared++;
          if (want.no_rule) idle_rules++;
          if (out_heater_power !== want.power) begin
            fail_count++;
            $display("%0t: heater_power mismatch: expected %0d, actual %0d",
                     $time, want.power, out_heater_power);
          end
          if (out_no_rule_fired !== want.no_rule) begin
            fail_count++;
            $display("%0t: no_rule_fired mismatch: expected %0b, actual %0b",
                     $time, want.no_rule, out_no_rule_fired);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_power_q.push_back(predict_heater_power(in_temperature, in_humidity));
      awaiting = expected_power_q.size();
    end
  end

endmodule

/* bench/fuzzy_heater_power_controller_tb.sv */
// Testbench top for the fuzzy heater power controller: stimulus, idling and verdict.
module fuzzy_heater_power_controller_tb;
  import fhpc_pkg::*;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [TEMP_W-1:0] in_temperature;
  logic [HUM_W-1:0]         in_humidity;
  logic                     out_valid;
  logic                     out_stall;
  logic [POWER_W-1:0]       out_heater_power;
  logic                     out_no_rule_fired;

  int fail_count;
  int awaiting;
  int compared;
  int idle_rules;
  int sent = 0;
  bit steady = 1'b0;  // when set, neither side idles

  always #4 clk = ~clk;

  fuzzy_heater_power_controller DUT (.*);

  fhpc_power_checker u_checker (.*);

  // Wait drawn per transaction, zero during steady stretches
  function automatic int draw_wait();
    if (steady) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Drive one sample transaction; starts and ends at a falling edge
  task automatic send_sample(input int t, input int h);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_temperature <= TEMP_W'(t);
    in_humidity    <= HUM_W'(h);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // Mostly samples on the slopes, some in range, some anywhere in the field
  task automatic random_sample();
    int t;
    int h;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) t = $urandom_range(100, 300);
    else if (pick < 8) t = int'($urandom_range(0, 2000)) - 500;
    else t = $urandom_range(0, 4095);
    pick = $urandom_range(0, 9);
    if (pick < 6) h = $urandom_range(250, 650);
    else if (pick < 8) h = $urandom_range(0, 1000);
    else h = $urandom_range(0, 1023);
    send_sample(t, h);
  endtask

  // Hold the sender until every expected result is back
  task automatic drain_pause();
    in_valid <= 1'b0;
    wait (awaiting == 0);
    @(negedge clk);
  endtask

  // Result side: stall a drawn number of cycles before each transaction
  initial begin : result_side
    int hold;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Stimulus
  initial begin : sample_side
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_temperature = '0;
    in_humidity    = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Field extremes, breakpoints, flat edges and no-rule cases
    send_sample(-2048, 0);
    send_sample(2047, 1023);
    send_sample(-500, 0);
    send_sample(1500, 1000);
    send_sample(150, 300);
    send_sample(170, 400);
    send_sample(200, 500);
    send_sample(230, 600);
    send_sample(250, 1000);
    send_sample(175, 350);
    send_sample(160, 320);
    send_sample(240, 550);
    send_sample(210, 450);
    send_sample(100, 450);   // nothing fires
    send_sample(200, 0);     // nothing fires at the temperature crossover
    send_sample(-2048, 450); // nothing fires, most negative code
    send_sample(-1, 1023);
    send_sample(0, 512);
    send_sample(185, 365);
    send_sample(2047, 0);
    send_sample(-2048, 1023);
    send_sample(199, 399);
    send_sample(201, 601);
    send_sample(151, 301);
    send_sample(249, 599);
    drain_pause();

    // Random samples with idle-free stretches and one mid-run drain
    for (int i = 0; i < 850; i++) begin
      if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      if (i == 425) drain_pause();
      random_sample();
    end
    steady = 1'b0;

    // Let the pipeline empty, then watch for stray results
    in_valid <= 1'b0;
    wait (awaiting == 0);
    repeat (30) @(posedge clk);

    $display("Summary: %0d samples sent (25 directed), %0d results compared, %0d with no rule.",
             sent, compared, idle_rules);
    $display("Summary: both sides idled 0..18 cycles per transaction, with idle-free runs.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3200000;
    $display("Timeout with %0d results still awaited", awaiting);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
